// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising edge, during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/mssd_pkg.sv
// ----------------------------------------------------------------------------
// mssd_pkg
// Types, codes and tables of the multiplexed seven-segment driver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mssd_pkg;

    // Input item kinds, carried on tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Binary to BCD conversion sizes
    localparam int BIN_WIDTH  = 16;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_WIDTH  = 4 * BCD_DIGITS;
    localparam int CNT_WIDTH  = $clog2(BIN_WIDTH);

    // Digit codes
    localparam logic [3:0] BLANK_CODE = 4'd15;
    localparam logic [3:0] NINE_CODE  = 4'd9;

    // Segment patterns of the decimal digits
    localparam logic [7:0] SEG_TABLE [10] = '{
        8'h7E, 8'h0C, 8'hB6, 8'h9E, 8'hCC, 8'hDA, 8'hFA, 8'h0E, 8'hFE, 8'hDE
    };

    // Map a digit code to its pattern; non-decimal codes stay dark
    function automatic logic [7:0] seg_pattern(input logic [3:0] code);
        logic [7:0] pat;
        pat = 8'h00;
        if (code < 4'd10)
        begin
            pat = SEG_TABLE[code];
        end
        return pat;
    endfunction

endpackage

// File: src/multiplexed_seven_segment_driver.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver
// Stores a number as decimal digits and scans them out one digit per tick.
// ----------------------------------------------------------------------------
// Tick item: result is registered, valid in the cycle after acceptance; one tick
//   per cycle while the output is taken.
// Load item: busy through one accept, 16 shift-and-adjust steps of the shared
//   BCD unit and one store write; an overflowing value is stored as all nines.
// Reset (async, rst_n low): digit store all zeros, scan index 0, no result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiplexed_seven_segment_driver #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] segments, [11:8] digit_enable, [15:12] zero
);

    import mssd_pkg::*;

    `include "assert_macros.svh"

    // Largest value that fits in the digit count
    function automatic logic [31:0] max_of(input int n);
        logic [31:0] m;
        m = 32'd1;
        for (int k = 0; k < n; k++)
        begin
            m = m * 32'd10;
        end
        return m - 32'd1;
    endfunction

    localparam logic [31:0] MaxValue = max_of(DIGIT_COUNT);
    localparam logic [2:0]  TopIdx   = 3'(DIGIT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CONV  = 3'b010,
        S_WRITE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [BIN_WIDTH-1:0]   bin_reg, bin_next;
    logic [BCD_WIDTH-1:0]   bcd_reg, bcd_next;
    logic [3:0]             digit_reg [DIGIT_COUNT];
    logic [3:0]             digit_next [DIGIT_COUNT];
    logic [1:0]             scan_reg, scan_next;
    logic                   out_valid_reg, out_valid_next;
    logic [15:0]            out_data_reg, out_data_next;

    logic                   in_acc;
    logic                   is_load;
    logic                   load_acc;
    logic                   out_held;
    logic                   overflow;
    logic [BCD_WIDTH-1:0]   bcd_adj;
    logic [31:0]            bcd_ext;
    logic [3:0]             cur_code;
    logic [2:0]             en_shift;
    logic [7:0]             en_wide;

    // Accept only when idle and the output register can take a result
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign is_load  = (s_tuser == CMD_LOAD);
    assign load_acc = in_acc && is_load;
    assign out_held = m_tvalid && !m_tready;
    assign overflow = {16'd0, s_tdata} > MaxValue;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Shared shift-and-adjust unit: add 3 to digits of 5 or more
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    assign bcd_ext = {{(32 - BCD_WIDTH){1'b0}}, bcd_reg};

    // Advance the scan index, wrapping at the top digit
    always_comb
    begin
        if ({1'b0, scan_reg} >= TopIdx)
        begin
            scan_next = 2'd0;
        end
        else
        begin
            scan_next = scan_reg + 2'd1;
        end
    end

    // Select the stored code of the new scan position
    always_comb
    begin
        cur_code = 4'd0;
        for (int k = 0; k < DIGIT_COUNT; k++)
        begin
            if ({1'b0, scan_next} == 3'(k))
            begin
                cur_code = digit_reg[k];
            end
        end
    end

    // Index 0 drives the highest enable bit
    assign en_shift = TopIdx - {1'b0, scan_next};
    assign en_wide  = 8'd1 << en_shift;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        digit_next     = digit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Drop the result once taken
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (!is_load)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {4'd0, en_wide[3:0], seg_pattern(cur_code)};
                    end
                    else if (overflow)
                    begin
                        for (int k = 0; k < DIGIT_COUNT; k++)
                        begin
                            digit_next[k] = NINE_CODE;
                        end
                    end
                    else
                    begin
                        bin_next   = s_tdata;
                        bcd_next   = '0;
                        cnt_next   = '0;
                        state_next = S_CONV;
                    end
                end
            end

            S_CONV:
            begin
                bcd_next = {bcd_adj[BCD_WIDTH-2:0], bin_reg[BIN_WIDTH-1]};
                bin_next = {bin_reg[BIN_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_WIDTH'(BIN_WIDTH - 1))
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                // Blank every digit above the highest nonzero one, keep the units
                for (int k = 0; k < DIGIT_COUNT; k++)
                begin
                    if ((k != 0) && ((bcd_ext >> (4 * k)) == 32'd0))
                    begin
                        digit_next[k] = BLANK_CODE;
                    end
                    else
                    begin
                        digit_next[k] = bcd_ext[4*k +: 4];
                    end
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Scan index moves on tick items only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= 2'd0;
        end
        else if (in_acc && !is_load)
        begin
            scan_reg <= scan_next;
        end
    end

    // Control state and digit store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DIGIT_COUNT; k++)
            begin
                digit_reg[k] <= 4'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            digit_reg     <= digit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        out_data_reg <= out_data_next;
    end

    // Busy sequencer never takes an item
    `ASSERT_CLK(a_busy_not_ready, (state_reg != S_IDLE) |-> !s_tready, "ready while busy")

    // A tick always leaves a result behind
    `ASSERT_CLK(a_tick_result, (in_acc && !is_load) |=> m_tvalid, "tick gave no result")

    // A load never creates a result
    `ASSERT_CLK(a_load_silent, load_acc |=> (m_tvalid == $past(out_held)), "load made a result")

    // The store write only follows the last conversion step
    `ASSERT_CLK(a_write_order, (state_reg == S_WRITE) |-> ($past(state_reg) == S_CONV), "store write out of order")

endmodule

// File: dv/multiplexed_seven_segment_driver_tb.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver_tb
// Self-checking bench for the four-digit display driver. A directed table
// covers the reset display, overflow, blank digits and the scan wrap; then
// random loads, each trailed by a burst of scan ticks, and loose noise items.
// Scan results are checked against exact rows or a local display predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiplexed_seven_segment_driver_tb;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_ITEMS    = 1850;
    localparam int IDLE_PCT        = 35;
    localparam int CALM_FIRST      = 700;
    localparam int CALM_LAST       = 1000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_REPORTS     = 10;
    localparam int DIRECTED_ROWS   = 24;

    localparam logic [15:0] MAX_SHOWN   = 16'd9999;
    localparam logic [3:0]  DIGIT_BLANK = 4'd15;
    localparam logic [3:0]  DIGIT_NINE  = 4'd9;

    // Row expectation source
    localparam logic FROM_PREDICTOR = 1'b0;
    localparam logic EXACT          = 1'b1;

    localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
        8'h7E, 8'h0C, 8'hB6, 8'h9E, 8'hCC, 8'hDA, 8'hFA, 8'h0E, 8'hFE, 8'hDE
    };

    typedef struct packed {
        logic [7:0] segments;
        logic [3:0] digit_enable;
    } scan_frame_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] value;
        logic        exact;
        logic [7:0]  segments;
        logic [3:0]  digit_enable;
    } stim_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Predictor state: digit codes units first, and the scan position
    logic [3:0]  shown_digits [4];
    logic [1:0]  scan_pos;

    scan_frame_t frame_q [$];
    stim_row_t   directed_rows [DIRECTED_ROWS];
    int          mismatches  = 0;
    bit          calm        = 1'b0;
    bit          random_part = 1'b0;

    multiplexed_seven_segment_driver dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Generate the 10 ns clock
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Update the display model with one item; report the scan frame of a tick
    task automatic advance_display(input logic cmd, input logic [15:0] val,
                                   output bit produced, output scan_frame_t frame);
        int unsigned rest;
        int          k;
        produced = 1'b0;
        frame    = '0;
        if (cmd == mssd_pkg::CMD_LOAD)
        begin
            if (val > MAX_SHOWN)
            begin
                for (k = 0; k < 4; k++)
                    shown_digits[k] = DIGIT_NINE;
            end
            else
            begin
                rest = val;
                k    = 0;
                do
                begin
                    shown_digits[k] = 4'(rest % 10);
                    rest = rest / 10;
                    k++;
                end while (rest != 0 && k < 4);
                for (; k < 4; k++)
                    shown_digits[k] = DIGIT_BLANK;
            end
        end
        else
        begin
            scan_pos = (scan_pos == 2'd3) ? 2'd0 : scan_pos + 2'd1;
            if (shown_digits[scan_pos] < 4'd10)
                frame.segments = DIGIT_SEGMENTS[shown_digits[scan_pos]];
            else
                frame.segments = 8'h00;
            frame.digit_enable = 4'b1000 >> scan_pos;
            produced = 1'b1;
        end
    endtask

    // Offer one item after a random gap, hold it until taken, then predict
    task automatic send_item(input stim_row_t row);
        bit          produced;
        scan_frame_t frame;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.cmd;
        s_tdata  <= row.value;
        do
            @(posedge clk);
        while (!s_tready);
        advance_display(row.cmd, row.value, produced, frame);
        if (produced)
        begin
            if (row.exact == EXACT)
                frame_q.push_back('{row.segments, row.digit_enable});
            else
                frame_q.push_back(frame);
        end
    endtask

    // Drive stimulus and decide the verdict
    initial
    begin
        stim_row_t row;
        int        sent;
        int        burst;
        int unsigned pick;
        directed_rows = '{
            '{mssd_pkg::CMD_TICK, 16'd0,     EXACT,          8'h7E, 4'b0100},
            '{mssd_pkg::CMD_TICK, 16'd0,     EXACT,          8'h7E, 4'b0010},
            '{mssd_pkg::CMD_TICK, 16'd0,     EXACT,          8'h7E, 4'b0001},
            '{mssd_pkg::CMD_TICK, 16'd0,     EXACT,          8'h7E, 4'b1000},
            '{mssd_pkg::CMD_LOAD, 16'hFFFF,  FROM_PREDICTOR, 8'h00, 4'b0000},
            '{mssd_pkg::CMD_TICK, 16'hFFFF,  EXACT,          8'hDE, 4'b0100},
            '{mssd_pkg::CMD_TICK, 16'd0,     EXACT,          8'hDE, 4'b0010},
            '{mssd_pkg::CMD_TICK, 16'd0,     EXACT,          8'hDE, 4'b0001},
            '{mssd_pkg::CMD_TICK, 16'd0,     EXACT,          8'hDE, 4'b1000},
            '{mssd_pkg::CMD_LOAD, 16'd0,     FROM_PREDICTOR, 8'h00, 4'b0000},
            '{mssd_pkg::CMD_TICK, 16'd0,     EXACT,          8'h00, 4'b0100},
            '{mssd_pkg::CMD_TICK, 16'd0,     EXACT,          8'h00, 4'b0010},
            '{mssd_pkg::CMD_TICK, 16'd0,     EXACT,          8'h00, 4'b0001},
            '{mssd_pkg::CMD_TICK, 16'd0,     EXACT,          8'h7E, 4'b1000},
            '{mssd_pkg::CMD_LOAD, 16'd9999,  FROM_PREDICTOR, 8'h00, 4'b0000},
            '{mssd_pkg::CMD_TICK, 16'd0,     FROM_PREDICTOR, 8'h00, 4'b0000},
            '{mssd_pkg::CMD_LOAD, 16'd10000, FROM_PREDICTOR, 8'h00, 4'b0000},
            '{mssd_pkg::CMD_TICK, 16'd0,     FROM_PREDICTOR, 8'h00, 4'b0000},
            '{mssd_pkg::CMD_LOAD, 16'd1000,  FROM_PREDICTOR, 8'h00, 4'b0000},
            '{mssd_pkg::CMD_TICK, 16'd0,     FROM_PREDICTOR, 8'h00, 4'b0000},
            '{mssd_pkg::CMD_LOAD, 16'd10,    FROM_PREDICTOR, 8'h00, 4'b0000},
            '{mssd_pkg::CMD_TICK, 16'd0,     FROM_PREDICTOR, 8'h00, 4'b0000},
            '{mssd_pkg::CMD_LOAD, 16'd5678,  FROM_PREDICTOR, 8'h00, 4'b0000},
            '{mssd_pkg::CMD_TICK, 16'd0,     FROM_PREDICTOR, 8'h00, 4'b0000}
        };
        for (int k = 0; k < 4; k++)
            shown_digits[k] = 4'd0;
        scan_pos = 2'd0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(directed_rows[r]);

        // Random part: mostly a load followed by a tick burst, some loose items
        random_part = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (sent >= CALM_FIRST && sent < CALM_LAST);
            row  = '0;
            row.exact = FROM_PREDICTOR;
            if ($urandom_range(99) < 70)
            begin
                pick = $urandom_range(3);
                case (pick)
                    0:       row.value = 16'($urandom_range(99));
                    1:       row.value = 16'($urandom_range(9999));
                    2:       row.value = 16'($urandom_range(10010, 9990));
                    default: row.value = 16'($urandom);
                endcase
                row.cmd = mssd_pkg::CMD_LOAD;
                send_item(row);
                sent++;
                burst = $urandom_range(8, 1);
                repeat (burst)
                begin
                    row.cmd   = mssd_pkg::CMD_TICK;
                    row.value = 16'($urandom);
                    send_item(row);
                    sent++;
                end
            end
            else
            begin
                row.cmd   = ($urandom_range(1) == 1) ? mssd_pkg::CMD_TICK
                                                     : mssd_pkg::CMD_LOAD;
                row.value = 16'($urandom);
                send_item(row);
                sent++;
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Drain outstanding frames, then allow for a late load to settle
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (frame_q.size() != 0)
        begin
            mismatches++;
            $display("%0d scan frames never arrived", frame_q.size());
        end
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Take and check scan frames; stall at random, once for a long stretch
    initial
    begin
        scan_frame_t want;
        int          held;
        bit          hold_done;
        held      = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (frame_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected scan frame: actual %h", m_tdata);
                end
                else
                begin
                    want = frame_q.pop_front();
                    if (m_tdata[7:0] !== want.segments
                        || m_tdata[11:8] !== want.digit_enable
                        || m_tdata[15:12] !== 4'h0)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("scan frame mismatch: segments exp %h act %h, enable exp %b act %b, pad act %h",
                                     want.segments, m_tdata[7:0],
                                     want.digit_enable, m_tdata[11:8], m_tdata[15:12]);
                    end
                end
            end
            if (random_part && !hold_done)
            begin
                // Hold off so the driver backs up into its input
                m_tready <= 1'b0;
                held++;
                if (held >= HOLD_OFF_CYCLES)
                    hold_done = 1'b1;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Abort when no item moves on either side for too long
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

endmodule
